[rtl/acmt_pkg.sv]
// Shared types and constants for the multi-channel timer core.
`timescale 1ns / 1ps
`default_nettype none
package acmt_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 12;
	localparam int unsigned IRQ_W    = 8;
	localparam int unsigned CTL_W    = 3;

	// channel register block layout
	localparam logic [ADDR_W-1:0] CH_STRIDE    = 12'h014;
	localparam logic [ADDR_W-1:0] R_LOAD       = 12'h000;
	localparam logic [ADDR_W-1:0] R_CURRENT    = 12'h004;
	localparam logic [ADDR_W-1:0] R_CONTROL    = 12'h008;
	localparam logic [ADDR_W-1:0] R_EOI        = 12'h00C;
	localparam logic [ADDR_W-1:0] R_STATUS     = 12'h010;

	// global registers
	localparam logic [ADDR_W-1:0] G_STATUS     = 12'h0A0;
	localparam logic [ADDR_W-1:0] G_EOI        = 12'h0A4;
	localparam logic [ADDR_W-1:0] G_RAW        = 12'h0A8;
	localparam logic [ADDR_W-1:0] G_VERSION    = 12'h0AC;
	localparam logic [ADDR_W-1:0] G_LOAD2      = 12'h0B0;

	localparam logic [DATA_W-1:0] VERSION_WORD = 32'h3230_352A;

	// control bit positions
	localparam int unsigned CTL_ENABLE   = 0;
	localparam int unsigned CTL_PERIODIC = 1;
	localparam int unsigned CTL_MASK     = 2;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] bus_address;
		logic [DATA_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic [IRQ_W-1:0]  irq_lines;
	} rsp_t;

	// per-channel strobes for one transaction
	typedef struct packed {
		logic tick;
		logic wr_load;
		logic wr_load2;
		logic wr_ctl;
		logic clr_pend;
	} ch_cmd_t;

	// per-channel register view
	typedef struct packed {
		logic [DATA_W-1:0] load;
		logic [DATA_W-1:0] load2;
		logic [CTL_W-1:0]  ctl;
		logic              pending;
		logic [DATA_W-1:0] count;
		logic              irq_next;
	} ch_view_t;

endpackage
`default_nettype wire

[rtl/acmt_channel.sv]
// One timer channel: load registers, control, pending flag and down counter.
`timescale 1ns / 1ps
`default_nettype none
module acmt_channel (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire acmt_pkg::ch_cmd_t         cmd,
	input  wire logic [acmt_pkg::DATA_W-1:0] wdata,
	output acmt_pkg::ch_view_t             view
);
	import acmt_pkg::*;

	logic [DATA_W-1:0] load_q, load2_q, count_q, count_n, start_val;
	logic [CTL_W-1:0]  ctl_q, ctl_n;
	logic              pend_q, pend_n;

	assign start_val = (load_q == '0) ? {{(DATA_W-1){1'b0}}, 1'b1} : load_q;

	always_comb begin
		ctl_n   = ctl_q;
		pend_n  = pend_q;
		count_n = count_q;
		if (cmd.tick && ctl_q[CTL_ENABLE]) begin
			// expire on 1 or 0
			if (count_q <= {{(DATA_W-1){1'b0}}, 1'b1}) begin
				pend_n  = 1'b1;
				count_n = ctl_q[CTL_PERIODIC] ? start_val : '1;
			end else begin
				count_n = count_q - DATA_W'(1);
			end
		end
		if (cmd.wr_ctl) begin
			ctl_n = wdata[CTL_W-1:0];
			if (wdata[CTL_ENABLE] && !ctl_q[CTL_ENABLE]) begin
				count_n = start_val;
			end
			if (!wdata[CTL_ENABLE] && ctl_q[CTL_ENABLE]) begin
				pend_n = 1'b0;
			end
		end
		if (cmd.clr_pend) begin
			pend_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q  <= '0;
			load2_q <= '0;
			ctl_q   <= '0;
			pend_q  <= 1'b0;
			count_q <= '1;
		end else begin
			if (cmd.wr_load) begin
				load_q <= wdata;
			end
			if (cmd.wr_load2) begin
				load2_q <= wdata;
			end
			ctl_q   <= ctl_n;
			pend_q  <= pend_n;
			count_q <= count_n;
		end
	end

	always_comb begin
		view.load     = load_q;
		view.load2    = load2_q;
		view.ctl      = ctl_q;
		view.pending  = pend_q;
		view.count    = count_q;
		view.irq_next = pend_n & ~ctl_n[CTL_MASK];
	end

endmodule
`default_nettype wire

[rtl/apb_multi_channel_timer_core.sv]
// Multi-channel timer core: input register, address decode, channel bank, result register.
// Flow: an accepted transaction moves from the input register into the result register
// once that register is free. A tick decrements or reloads all enabled counters at once.
// Throughput: one transaction per cycle unless a stalled result holds the input register.
// A new transaction enters while a result waits only if the input register is empty.
// Reset: asynchronous, clears valid flags and channel state; counters reset to all ones.
`timescale 1ns / 1ps
`default_nettype none
module apb_multi_channel_timer_core #(
	parameter int unsigned CHANNELS = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire acmt_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output acmt_pkg::rsp_t      rsp
);
	import acmt_pkg::*;

	logic              valid_s1;
	req_t              req_s1;
	logic              advance;
	logic              is_tick, is_read, is_write;
	logic [DATA_W-1:0] rdata;
	logic [IRQ_W-1:0]  irq_next;
	logic [DATA_W-1:0] masked_vec, raw_vec;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	ch_cmd_t  cmd  [CHANNELS];
	ch_view_t view [CHANNELS];

	assign advance   = valid_s1 && !(rsp_valid_q && rsp_stall);
	assign req_stall = valid_s1 && rsp_valid_q && rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	assign is_tick  = advance && (func_t'(req_s1.func) == FUNC_TICK);
	assign is_read  = advance && (func_t'(req_s1.func) == FUNC_READ);
	assign is_write = advance && (func_t'(req_s1.func) == FUNC_WRITE);

	for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
		localparam logic [ADDR_W-1:0] BASE = ADDR_W'(i * CH_STRIDE);
		localparam logic [ADDR_W-1:0] L2   = ADDR_W'(G_LOAD2 + 4 * i);

		logic l2_hit;
		assign l2_hit = (req_s1.bus_address[ADDR_W-1:2] == L2[ADDR_W-1:2]);

		always_comb begin
			cmd[i].tick     = is_tick;
			cmd[i].wr_load  = is_write && (req_s1.bus_address == BASE + R_LOAD);
			cmd[i].wr_ctl   = is_write && (req_s1.bus_address == BASE + R_CONTROL);
			cmd[i].wr_load2 = is_write && l2_hit;
			cmd[i].clr_pend = is_read && ((req_s1.bus_address == BASE + R_EOI) ||
				(req_s1.bus_address == G_EOI));
		end

		acmt_channel u_channel (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd[i]),
			.wdata (req_s1.write_data),
			.view  (view[i])
		);
	end

	// read mux and status vectors
	always_comb begin
		rdata      = '0;
		irq_next   = '0;
		masked_vec = '0;
		raw_vec    = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			raw_vec[i]    = view[i].pending;
			masked_vec[i] = view[i].pending & ~view[i].ctl[CTL_MASK];
			irq_next[i]   = view[i].irq_next;
			if (req_s1.bus_address == ADDR_W'(i * CH_STRIDE) + R_LOAD) begin
				rdata = rdata | view[i].load;
			end
			if (req_s1.bus_address == ADDR_W'(i * CH_STRIDE) + R_CURRENT &&
				view[i].ctl[CTL_ENABLE]) begin
				rdata = rdata | view[i].count;
			end
			if (req_s1.bus_address == ADDR_W'(i * CH_STRIDE) + R_CONTROL) begin
				rdata = rdata | {{(DATA_W-CTL_W){1'b0}}, view[i].ctl};
			end
			if (req_s1.bus_address == ADDR_W'(i * CH_STRIDE) + R_STATUS) begin
				rdata = rdata | {{(DATA_W-1){1'b0}},
					view[i].pending & ~view[i].ctl[CTL_MASK]};
			end
			if (req_s1.bus_address[ADDR_W-1:2] ==
				(ADDR_W-2)'((G_LOAD2 + 4 * i) >> 2)) begin
				rdata = rdata | view[i].load2;
			end
		end
		case (req_s1.bus_address)
			G_STATUS:  rdata = masked_vec;
			G_RAW:     rdata = raw_vec;
			G_VERSION: rdata = VERSION_WORD;
			default:   ;
		endcase
		if (!is_read) begin
			rdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.read_data <= rdata;
			rsp_q.irq_lines <= irq_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

[rtl/acmt_checker.sv]
// Port-level assertions for the timer core and their bind.
`timescale 1ns / 1ps
`default_nettype none
module acmt_checker #(
	parameter int unsigned CHANNELS = 8
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire acmt_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire acmt_pkg::rsp_t rsp
);
	import acmt_pkg::*;

	logic [IRQ_W-1:0] unused_irq;
	always_comb begin
		unused_irq = '1;
		for (int i = 0; i < IRQ_W; i++) begin
			if (i < CHANNELS) begin
				unused_irq[i] = 1'b0;
			end
		end
	end

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// input side only stalls when the result side is blocked
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid || !rsp_stall) |-> !req_stall)
		else $error("input stalled with result side free");

	// a version read followed by a free result side returns the version word
	a_version: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req.func == FUNC_READ &&
			req.bus_address == G_VERSION) ##1 (!rsp_valid || !rsp_stall)
		|=> rsp_valid && rsp.read_data == VERSION_WORD)
		else $error("version read mismatch");

	// no interrupt on channels that are not built
	a_irq_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.irq_lines & unused_irq) == '0)
		else $error("interrupt on missing channel");

endmodule

bind apb_multi_channel_timer_core acmt_checker #(.CHANNELS(CHANNELS)) u_acmt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
`default_nettype wire

[tb/tb_apb_multi_channel_timer_core.sv]
// Self-checking testbench for the multi-channel timer core: directed table, then random traffic.
`timescale 1ns / 1ps
module tb_apb_multi_channel_timer_core;
	import acmt_pkg::*;

	localparam int unsigned NCH        = 8;
	localparam int unsigned RAND_ITEMS = 1800;
	localparam int unsigned CALM_ITEMS = 150;
	localparam int unsigned CYCLE_CAP  = 200000;
	localparam int unsigned DIR_N      = 27;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	apb_multi_channel_timer_core #(.CHANNELS(NCH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the timer bank
	logic [DATA_W-1:0] load_sh [NCH];
	logic [DATA_W-1:0] load2_sh [NCH];
	logic [CTL_W-1:0]  ctl_sh [NCH];
	logic              pend_sh [NCH];
	logic [DATA_W-1:0] count_sh [NCH];

	rsp_t due_rsp_q[$];
	int unsigned fail_count = 0;
	int unsigned tick_cnt = 0, read_cnt = 0, write_cnt = 0, expiry_cnt = 0, irq_seen = 0;
	bit idle_on = 1'b1;
	int unsigned stall_left = 0;
	int unsigned cycle_cnt = 0;

	typedef struct {
		func_t             f;
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		bit                typed;
		logic [DATA_W-1:0] rd;
	} dir_row_t;

	dir_row_t dir_rows [DIR_N];

	function automatic logic [DATA_W-1:0] start_count(int unsigned ch);
		return (load_sh[ch] == '0) ? 32'd1 : load_sh[ch];
	endfunction

	function automatic logic [IRQ_W-1:0] pending_vector(bit masked);
		logic [IRQ_W-1:0] v;
		v = '0;
		for (int i = 0; i < NCH; i++)
			if (!(masked && ctl_sh[i][CTL_MASK]))
				v[i] = pend_sh[i];
		return v;
	endfunction

	function automatic void clear_bank();
		for (int i = 0; i < NCH; i++) begin
			load_sh[i] = '0;
			load2_sh[i] = '0;
			ctl_sh[i] = '0;
			pend_sh[i] = 1'b0;
			count_sh[i] = '1;
		end
	endfunction

	// advances the shadow by one transaction and returns the response it must produce
	function automatic rsp_t step_timer_bank(req_t t);
		rsp_t r;
		int unsigned a, ch, off;
		logic [CTL_W-1:0] old;
		r = '0;
		a = t.bus_address;
		ch = a / CH_STRIDE;
		off = a % CH_STRIDE;
		case (func_t'(t.func))
			FUNC_TICK: begin
				tick_cnt++;
				for (int i = 0; i < NCH; i++) begin
					if (ctl_sh[i][CTL_ENABLE]) begin
						if (count_sh[i] <= 1) begin
							pend_sh[i] = 1'b1;
							count_sh[i] = ctl_sh[i][CTL_PERIODIC] ? start_count(i) : '1;
							expiry_cnt++;
						end else begin
							count_sh[i] = count_sh[i] - 1;
						end
					end
				end
			end
			FUNC_READ: begin
				read_cnt++;
				if (a < G_STATUS) begin
					if (off == R_LOAD)
						r.read_data = load_sh[ch];
					else if (off == R_CURRENT)
						r.read_data = ctl_sh[ch][CTL_ENABLE] ? count_sh[ch] : '0;
					else if (off == R_CONTROL)
						r.read_data = DATA_W'(ctl_sh[ch]);
					else if (off == R_EOI)
						pend_sh[ch] = 1'b0;
					else if (off == R_STATUS)
						r.read_data = DATA_W'(ctl_sh[ch][CTL_MASK] ? 1'b0 : pend_sh[ch]);
				end else if (a >= G_LOAD2 && a < G_LOAD2 + NCH * 4) begin
					r.read_data = load2_sh[(a - G_LOAD2) / 4];
				end else if (a == G_STATUS) begin
					r.read_data = DATA_W'(pending_vector(1'b1));
				end else if (a == G_EOI) begin
					for (int i = 0; i < NCH; i++)
						pend_sh[i] = 1'b0;
				end else if (a == G_RAW) begin
					r.read_data = DATA_W'(pending_vector(1'b0));
				end else if (a == G_VERSION) begin
					r.read_data = VERSION_WORD;
				end
			end
			FUNC_WRITE: begin
				write_cnt++;
				if (a < G_STATUS) begin
					if (off == R_LOAD) begin
						load_sh[ch] = t.write_data;
					end else if (off == R_CONTROL) begin
						old = ctl_sh[ch];
						ctl_sh[ch] = t.write_data[CTL_W-1:0];
						if (t.write_data[CTL_ENABLE] != old[CTL_ENABLE]) begin
							if (t.write_data[CTL_ENABLE])
								count_sh[ch] = start_count(ch);
							else
								pend_sh[ch] = 1'b0;
						end
					end
				end else if (a >= G_LOAD2 && a < G_LOAD2 + NCH * 4) begin
					load2_sh[(a - G_LOAD2) / 4] = t.write_data;
				end
			end
			default: ;
		endcase
		r.irq_lines = pending_vector(1'b1);
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] pick_load_value();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return $urandom_range(0, 12);
		else if (p < 80)
			return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		return $urandom;
	endfunction

	// mostly register traffic with timers kept short so expiries happen often
	function automatic req_t random_item();
		req_t t;
		int unsigned p, ch, sel;
		logic [CTL_W-1:0] c;
		t.func = FUNC_TICK;
		t.bus_address = ADDR_W'($urandom_range(0, 4095));
		t.write_data = $urandom;
		p = $urandom_range(0, 99);
		ch = $urandom_range(0, NCH - 1);
		if (p < 40) begin
			t.func = FUNC_TICK;
		end else if (p < 65) begin
			t.func = FUNC_READ;
			sel = $urandom_range(0, 9);
			case (sel)
				0, 1, 2, 3, 4: t.bus_address = ADDR_W'(ch * CH_STRIDE + sel * 4);
				5: t.bus_address = G_STATUS;
				6: t.bus_address = G_EOI;
				7: t.bus_address = G_RAW;
				8: t.bus_address = G_VERSION;
				default: t.bus_address = ADDR_W'(G_LOAD2 + ch * 4 + $urandom_range(0, 3));
			endcase
		end else if (p < 88) begin
			t.func = FUNC_WRITE;
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				c = CTL_W'($urandom_range(0, 7));
				if ($urandom_range(0, 9) < 7)
					c[CTL_ENABLE] = 1'b1;
				t.bus_address = ADDR_W'(ch * CH_STRIDE + R_CONTROL);
				t.write_data = {t.write_data[DATA_W-1:CTL_W], c};
			end else if (sel < 85) begin
				t.bus_address = ADDR_W'(ch * CH_STRIDE + R_LOAD);
				t.write_data = pick_load_value();
			end else begin
				t.bus_address = ADDR_W'(G_LOAD2 + ch * 4 + $urandom_range(0, 3));
			end
		end else begin
			t.func = 2'($urandom_range(0, 3));
		end
		return t;
	endfunction

	task automatic send_item(input req_t t, input bit typed, input logic [DATA_W-1:0] rd);
		rsp_t e;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= t;
		do @(posedge clk); while (req_stall);
		e = step_timer_bank(t);
		if (typed)
			e.read_data = rd;
		due_rsp_q.push_back(e);
	endtask

	// result-side stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				rsp_stall <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rsp_stall <= 1'b1;
			stall_left <= $urandom_range(1, 6);
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_rsp_q.size() == 0) begin
				$error("response transaction with nothing expected: read_data %h irq_lines %h",
					rsp.read_data, rsp.irq_lines);
				fail_count++;
			end else begin
				e = due_rsp_q.pop_front();
				if (rsp.irq_lines != 0)
					irq_seen++;
				if (rsp.read_data !== e.read_data) begin
					$error("read_data expected %h actual %h", e.read_data, rsp.read_data);
					fail_count++;
				end
				if (rsp.irq_lines !== e.irq_lines) begin
					$error("irq_lines expected %h actual %h", e.irq_lines, rsp.irq_lines);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		req_t t;
		dir_rows = '{
			'{FUNC_READ,  G_VERSION, 32'h0,          1'b1, VERSION_WORD},
			'{FUNC_READ,  12'h008,   32'h0,          1'b1, 32'h0},
			'{FUNC_READ,  12'h090,   32'h0,          1'b1, 32'h0},
			'{FUNC_READ,  G_LOAD2,   32'h0,          1'b1, 32'h0},
			'{FUNC_NONE,  12'hFFF,   32'hFFFF_FFFF,  1'b1, 32'h0},
			'{FUNC_READ,  12'hFFF,   32'h0,          1'b1, 32'h0},
			'{FUNC_WRITE, 12'h000,   32'h0,          1'b0, 32'h0},
			'{FUNC_WRITE, 12'h008,   32'h3,          1'b0, 32'h0},
			'{FUNC_TICK,  12'h000,   32'h0,          1'b0, 32'h0},
			'{FUNC_READ,  12'h010,   32'h0,          1'b0, 32'h0},
			'{FUNC_READ,  G_STATUS,  32'h0,          1'b0, 32'h0},
			'{FUNC_READ,  12'h00C,   32'h0,          1'b0, 32'h0},
			'{FUNC_WRITE, 12'h08C,   32'hFFFF_FFFF,  1'b0, 32'h0},
			'{FUNC_WRITE, 12'h0CF,   32'hFFFF_FFFF,  1'b0, 32'h0},
			'{FUNC_READ,  12'h0CC,   32'h0,          1'b0, 32'h0},
			'{FUNC_WRITE, 12'h094,   32'hFFFF_FFFD,  1'b0, 32'h0},
			'{FUNC_WRITE, 12'h01C,   32'h1,          1'b0, 32'h0},
			'{FUNC_TICK,  12'hFFF,   32'hFFFF_FFFF,  1'b0, 32'h0},
			'{FUNC_READ,  12'h018,   32'h0,          1'b0, 32'h0},
			'{FUNC_READ,  G_RAW,     32'h0,          1'b0, 32'h0},
			'{FUNC_WRITE, 12'h01C,   32'h0,          1'b0, 32'h0},
			'{FUNC_WRITE, G_VERSION, 32'h0,          1'b0, 32'h0},
			'{FUNC_READ,  12'h03A,   32'h0,          1'b1, 32'h0},
			'{FUNC_READ,  G_EOI,     32'h0,          1'b0, 32'h0},
			'{FUNC_READ,  12'h0D0,   32'h0,          1'b1, 32'h0},
			'{FUNC_WRITE, 12'h004,   32'hFFFF_FFFF,  1'b0, 32'h0},
			'{FUNC_READ,  12'h094,   32'h0,          1'b0, 32'h0}
		};
		clear_bank();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			t.func = dir_rows[i].f;
			t.bus_address = dir_rows[i].a;
			t.write_data = dir_rows[i].d;
			send_item(t, dir_rows[i].typed, dir_rows[i].rd);
		end

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// idling switched per stretch, none at the tail
			if (n % 200 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (n >= RAND_ITEMS - CALM_ITEMS)
				idle_on = 1'b0;
			send_item(random_item(), 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (due_rsp_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d ticks, %0d reads, %0d writes over the directed table and random traffic.",
			tick_cnt, read_cnt, write_cnt);
		$display("Channel expiries: %0d; responses with an interrupt line high: %0d.",
			expiry_cnt, irq_seen);
		if (fail_count == 0 && due_rsp_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
